// ----- src/wvc_pkg.sv -----
// Shared types and constants of the waypoint velocity command unit.
package wvc_pkg;

  localparam logic [15:0] MIN_SLOWDOWN = 16'd104;
  localparam logic [19:0] TWO_PI_Q16   = 20'd411775;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
    32'd1,         32'd0
  };

  typedef enum logic [1:0] {
    REG_GOAL_TOL = 2'd0,
    REG_SLOWDOWN = 2'd1,
    REG_LIN_GAIN = 2'd2,
    REG_ANG_GAIN = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] arrive_tol;
    logic [15:0] slowdown_angle;
    logic [15:0] fwd_gain;
    logic [15:0] turn_gain;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        reach;
    logic signed [16:0] err;
    logic               arrived;
  } side_t;

endpackage

// ----- src/wvc_cfg.sv -----
// Configuration register file behind the APB port.
module wvc_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output wvc_pkg::cfg_t     cfg_o
);
  import wvc_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.arrive_tol     <= 32'd6554;
      cfg_q.slowdown_angle <= 16'd16384;
      cfg_q.fwd_gain       <= 16'd256;
      cfg_q.turn_gain      <= 16'd256;
    end else if (psel && penable && pwrite && pready) begin
      unique case (idx)
        REG_GOAL_TOL: cfg_q.arrive_tol     <= pwdata;
        REG_SLOWDOWN: cfg_q.slowdown_angle <= pwdata[15:0];
        REG_LIN_GAIN: cfg_q.fwd_gain       <= pwdata[15:0];
        REG_ANG_GAIN: cfg_q.turn_gain      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GOAL_TOL: prdata = cfg_q.arrive_tol;
      REG_SLOWDOWN: prdata = {16'd0, cfg_q.slowdown_angle};
      REG_LIN_GAIN: prdata = {16'd0, cfg_q.fwd_gain};
      REG_ANG_GAIN: prdata = {16'd0, cfg_q.turn_gain};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

// ----- src/wvc_geom.sv -----
// Distance and bearing pipeline: squares, bitwise square root and CORDIC vectoring.
module wvc_geom #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [32:0] dx_i,
  input  logic signed [32:0] dy_i,
  input  logic [15:0]        heading_i,
  output logic               valid_o,
  output logic [31:0]        dist_o,
  output logic [15:0]        bearing_o,
  output logic [15:0]        heading_o
);
  import wvc_pkg::*;

  localparam int unsigned NumRot = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int unsigned XW     = 36;
  localparam int unsigned NumSq  = 32;

  logic [32:0]          ax_full, ay_full;
  logic [63:0]          sx_d, sy_d;
  logic signed [XW-1:0] bx_d, by_d;
  logic [31:0]          bz_d;

  logic                 b_valid_q;
  logic [63:0]          sx_q, sy_q;
  logic signed [XW-1:0] bx_q, by_q;
  logic [31:0]          bz_q;
  logic [15:0]          bh_q;
  logic [64:0]          sum;

  logic                 v_q    [0:NumSq];
  logic [63:0]          s_q    [0:NumSq];
  logic                 sat_q  [0:NumSq];
  logic [33:0]          rem_q  [0:NumSq];
  logic [31:0]          root_q [0:NumSq];
  logic signed [XW-1:0] x_q    [0:NumSq];
  logic signed [XW-1:0] y_q    [0:NumSq];
  logic [31:0]          z_q    [0:NumSq];
  logic [15:0]          h_q    [0:NumSq];

  assign ax_full = dx_i[32] ? 33'(-dx_i) : 33'(dx_i);
  assign ay_full = dy_i[32] ? 33'(-dy_i) : 33'(dy_i);
  assign sx_d    = ax_full[31:0] * ax_full[31:0];
  assign sy_d    = ay_full[31:0] * ay_full[31:0];
  assign bx_d    = dx_i[32] ? -XW'(dx_i) : XW'(dx_i);
  assign by_d    = dx_i[32] ? -XW'(dy_i) : XW'(dy_i);
  assign bz_d    = dx_i[32] ? 32'h8000_0000 : 32'd0;
  assign sum     = {1'b0, sx_q} + {1'b0, sy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      v_q[0]    <= 1'b0;
    end else if (en_i) begin
      b_valid_q <= valid_i;
      v_q[0]    <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q      <= sx_d;
      sy_q      <= sy_d;
      bx_q      <= bx_d;
      by_q      <= by_d;
      bz_q      <= bz_d;
      bh_q      <= heading_i;
      s_q[0]    <= sum[63:0];
      sat_q[0]  <= sum[64];
      rem_q[0]  <= 34'd0;
      root_q[0] <= 32'd0;
      x_q[0]    <= bx_q;
      y_q[0]    <= by_q;
      z_q[0]    <= bz_q;
      h_q[0]    <= bh_q;
    end
  end

  for (genvar k = 0; k < NumSq; k++) begin : g_stage
    localparam int unsigned B = NumSq - 1 - k;
    logic [33:0]          rem_n, trial;
    logic                 ge;
    logic signed [XW-1:0] xs, ys, x_n, y_n;
    logic [31:0]          z_n;

    assign rem_n = {rem_q[k][31:0], s_q[k][2*B+1 -: 2]};
    assign trial = {root_q[k], 2'b01};
    assign ge    = rem_n >= trial;
    assign xs    = x_q[k] >>> k;
    assign ys    = y_q[k] >>> k;

    if (k < NumRot) begin : g_rot
      always_comb begin
        if (!y_q[k][XW-1]) begin
          x_n = x_q[k] + ys;
          y_n = y_q[k] - xs;
          z_n = z_q[k] + ATAN_TAB[k];
        end else begin
          x_n = x_q[k] - ys;
          y_n = y_q[k] + xs;
          z_n = z_q[k] - ATAN_TAB[k];
        end
      end
    end else begin : g_pass
      assign x_n = x_q[k];
      assign y_n = y_q[k];
      assign z_n = z_q[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[k+1]    <= s_q[k];
        sat_q[k+1]  <= sat_q[k];
        rem_q[k+1]  <= ge ? rem_n - trial : rem_n;
        root_q[k+1] <= {root_q[k][30:0], ge};
        x_q[k+1]    <= x_n;
        y_q[k+1]    <= y_n;
        z_q[k+1]    <= z_n;
        h_q[k+1]    <= h_q[k];
      end
    end
  end

  logic [31:0] z_rnd;
  assign z_rnd     = z_q[NumSq] + 32'h0000_8000;
  assign valid_o   = v_q[NumSq];
  assign dist_o    = sat_q[NumSq] ? 32'hFFFF_FFFF : root_q[NumSq];
  assign bearing_o = z_rnd[31:16];
  assign heading_o = h_q[NumSq];

endmodule

// ----- src/wvc_div.sv -----
// Pipelined restoring divider for the heading slowdown scale, one quotient bit per stage.
module wvc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [15:0]       num_i,
  input  logic [15:0]       den_i,
  input  wvc_pkg::side_t    side_i,
  output logic              valid_o,
  output logic [16:0]       quot_o,
  output wvc_pkg::side_t    side_o
);
  import wvc_pkg::*;

  localparam int unsigned NumBits = 17;

  logic        v_q    [0:NumBits];
  logic [16:0] r_q    [0:NumBits];
  logic [16:0] q_q    [0:NumBits];
  logic [15:0] d_q    [0:NumBits];
  side_t       side_q [0:NumBits];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= {1'b0, num_i};
      q_q[0]    <= 17'd0;
      d_q[0]    <= den_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar j = 0; j < NumBits; j++) begin : g_bit
    logic [16:0] r2;
    logic        ge;

    if (j == 0) begin : g_first
      assign r2 = r_q[j];
    end else begin : g_next
      assign r2 = {r_q[j][15:0], 1'b0};
    end
    assign ge = r2 >= {1'b0, d_q[j]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j+1]    <= ge ? r2 - {1'b0, d_q[j]} : r2;
        q_q[j+1]    <= {q_q[j][15:0], ge};
        d_q[j+1]    <= d_q[j];
        side_q[j+1] <= side_q[j];
      end
    end
  end

  assign valid_o = v_q[NumBits];
  assign quot_o  = q_q[NumBits];
  assign side_o  = side_q[NumBits];

endmodule

// ----- src/waypoint_velocity_command_unit.sv -----
// An accepted pose request passes input, geometry, divider, gain and output stages.
// Throughput: one request per cycle unless stalled; 32 square-root stages set depth.
// Every stage advances together whenever the output register is empty or taken.
// Reset clears all valid bits and loads the configuration registers with defaults.
// Top level of the waypoint velocity command unit.
module waypoint_velocity_command_unit #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pose_x[31:0], pose_y[63:32], pose_heading[79:64], goal_x[111:80], goal_y[143:112]
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // forward_speed[30:0], turn_rate[62:31], zero[63]
  output logic [63:0]  m_axis_tdata,
  // arrived[0]
  output logic         m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import wvc_pkg::*;

  cfg_t cfg;
  logic adv;

  wvc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  logic out_valid_q;
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  logic signed [31:0] px, py, gx, gy;
  logic signed [32:0] dx_d, dy_d, dx_q, dy_q;
  logic [15:0]        hdg_q;
  logic               a_valid_q;

  assign px   = s_axis_tdata[31:0];
  assign py   = s_axis_tdata[63:32];
  assign gx   = s_axis_tdata[111:80];
  assign gy   = s_axis_tdata[143:112];
  assign dx_d = 33'(gx) - 33'(px);
  assign dy_d = 33'(gy) - 33'(py);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      hdg_q <= s_axis_tdata[79:64];
    end
  end

  logic        g_valid;
  logic [31:0] g_dist;
  logic [15:0] g_bear, g_hdg;

  wvc_geom #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_geom (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (a_valid_q),
    .dx_i     (dx_q),
    .dy_i     (dy_q),
    .heading_i(hdg_q),
    .valid_o  (g_valid),
    .dist_o   (g_dist),
    .bearing_o(g_bear),
    .heading_o(g_hdg)
  );

  logic [15:0] d16, ae, m_ang, num;
  side_t       side_d;

  assign d16          = g_bear - g_hdg;
  assign ae           = d16[15] ? 16'(-d16) : d16;
  assign m_ang        = (cfg.slowdown_angle < MIN_SLOWDOWN) ? MIN_SLOWDOWN
                                                             : cfg.slowdown_angle;
  assign num          = (ae >= m_ang) ? 16'd0 : m_ang - ae;
  assign side_d.reach   = g_dist;
  assign side_d.err     = {d16[15], d16};
  assign side_d.arrived = g_dist <= cfg.arrive_tol;

  logic        dv_valid;
  logic [16:0] dv_quot;
  side_t       dv_side;

  wvc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(g_valid),
    .num_i  (num),
    .den_i  (m_ang),
    .side_i (side_d),
    .valid_o(dv_valid),
    .quot_o (dv_quot),
    .side_o (dv_side)
  );

  logic               e_valid_q, e_arr_q;
  logic [32:0]        p1_q;
  logic signed [33:0] t1_q;
  logic [31:0]        e_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (adv) begin
      e_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q     <= cfg.fwd_gain * dv_quot;
      t1_q     <= $signed({1'b0, cfg.turn_gain}) * dv_side.err;
      e_dist_q <= dv_side.reach;
      e_arr_q  <= dv_side.arrived;
    end
  end

  logic [64:0]        fprod;
  logic [30:0]        fwd_d, fwd_q;
  logic signed [54:0] tprod, trnd;
  logic [31:0]        turn_d, turn_q;
  logic               arr_q;

  assign fprod  = p1_q * e_dist_q;
  assign fwd_d  = (|fprod[64:55]) ? 31'h7FFF_FFFF : fprod[54:24];
  assign tprod  = t1_q * $signed({1'b0, TWO_PI_Q16});
  assign trnd   = (tprod + 55'sd8388608) >>> 24;
  assign turn_d = trnd[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fwd_q  <= e_arr_q ? 31'd0 : fwd_d;
      turn_q <= e_arr_q ? 32'd0 : turn_d;
      arr_q  <= e_arr_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, turn_q, fwd_q};
  assign m_axis_tuser  = arr_q;

  a_arrived_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 64'd0)
    else $error("arrived result carries nonzero speeds");

  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stage");

  a_rise_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv))
    else $error("output valid rose without an advance");

  a_scale_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_valid |-> dv_quot <= 17'd65536)
    else $error("heading scale above one");

endmodule
